// ===== src/voice_allocator_round_robin_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VOICE_ALLOCATOR_ROUND_ROBIN_UNIT_MACROS_SVH
`define VOICE_ALLOCATOR_ROUND_ROBIN_UNIT_MACROS_SVH

// same-cycle implication
`define VARA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VARA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vara_pkg.sv =====
// ----------------------------------------------------------------------------
// Voice allocator package
// Transaction types, field widths and event / route codes.
// ----------------------------------------------------------------------------
package vara_pkg;

  localparam int VOICES_DEF = 8;
  localparam int NOTES      = 128;
  localparam int NOTE_W     = 7;
  localparam int KIND_W     = 2;
  localparam int ROUTE_W    = 2;
  localparam int VOICE_W    = 3;

  localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;

  localparam logic [ROUTE_W-1:0] ROUTE_DROP = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_ONE  = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_ALL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NOTE_W-1:0] note;
  } midi_t;

  typedef struct packed {
    logic [ROUTE_W-1:0] route;
    logic [VOICE_W-1:0] voice;
  } alloc_t;

endpackage

// ===== src/voice_allocator_round_robin_unit.sv =====
// ----------------------------------------------------------------------------
// Round-robin voice allocator
// Routes MIDI note events to synthesiser voices, descending round robin.
// ----------------------------------------------------------------------------
// Channels: midi (kind, note) in, alloc (route, voice) out, both valid/stall.
// One alloc transaction follows every midi transaction, in order.
// Each event runs through a three-step sequencer: accept (voice note and
// note map read), look-up (unmap the displaced note, resolve the target)
// and commit (map and voice table update, result registered). alloc_valid
// therefore rises as commit completes, and the block takes no new event
// until commit completes; midi_stall is high during look-up and commit.
// The single-port note map and voice note reads set this step order.
// The result sits in an output register, so a new event is accepted while
// it waits; if alloc_stall holds, the next event waits in commit.
// Reset clears the voice pointer to the top voice and clears the map and
// voice valid flags directly; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "voice_allocator_round_robin_unit_macros.svh"

module voice_allocator_round_robin_unit #(
  parameter int VOICES = vara_pkg::VOICES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  vara_pkg::midi_t  midi,
  input  logic            midi_valid,
  output logic            midi_stall,
  output vara_pkg::alloc_t alloc,
  output logic            alloc_valid,
  input  logic            alloc_stall
);
  import vara_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] TOP_VOICE = VW'(VOICES - 1);

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    LOOK   = 3'b010,
    COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [VW-1:0]     next_voice;
  logic [VOICES-1:0] vn_valid;
  logic [NOTES-1:0]  nm_valid;

  logic [NOTE_W-1:0] vn_mem [VOICES];
  logic [VW-1:0]     nm_mem [NOTES];

  logic [NOTE_W-1:0] vn_rd;
  logic              vn_vld_q;
  logic [VW-1:0]     nm_rd;

  logic [KIND_W-1:0]  kind_q;
  logic [NOTE_W-1:0]  note_q;
  logic [ROUTE_W-1:0] route_q;
  logic [VW-1:0]      tgt_q;
  logic [NOTE_W-1:0]  held;

  logic accept;
  logic commit_go;

  assign midi_stall = (state != IDLE);
  assign accept     = midi_valid && (state == IDLE);
  assign commit_go  = (state == COMMIT) && (!alloc_valid || !alloc_stall);
  assign held       = vn_vld_q ? vn_rd : '0;

  always_comb begin
    state_next = state;
    unique case (state)
      IDLE: begin
        if (accept) state_next = LOOK;
      end
      LOOK: begin
        state_next = COMMIT;
      end
      COMMIT: begin
        if (commit_go) state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      next_voice  <= TOP_VOICE;
      vn_valid    <= '0;
      nm_valid    <= '0;
      alloc_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_go) begin
        alloc_valid <= 1'b1;
      end else if (alloc_valid && !alloc_stall) begin
        alloc_valid <= 1'b0;
      end
      if (state == LOOK && kind_q == KIND_ON && held != '0) nm_valid[held] <= 1'b0;
      if (commit_go) begin
        if (kind_q == KIND_ON) begin
          nm_valid[note_q] <= 1'b1;
          vn_valid[tgt_q]  <= 1'b1;
          next_voice       <= (next_voice == '0) ? TOP_VOICE : next_voice - 1'b1;
        end else if (kind_q == KIND_OFF && route_q == ROUTE_ONE) begin
          nm_valid[note_q] <= 1'b0;
          vn_valid[tgt_q]  <= 1'b0;
        end
      end
    end
  end

  // transaction payload and sequencer data
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= midi.kind;
      note_q <= midi.note;
    end
    if (state == LOOK) begin
      priority if (kind_q == KIND_ON) begin
        route_q <= ROUTE_ONE;
        tgt_q   <= next_voice;
      end else if (kind_q == KIND_OFF && nm_valid[note_q]) begin
        route_q <= ROUTE_ONE;
        tgt_q   <= nm_rd;
      end else if (kind_q == KIND_OFF) begin
        route_q <= ROUTE_DROP;
        tgt_q   <= '0;
      end else begin
        route_q <= ROUTE_ALL;
        tgt_q   <= '0;
      end
    end
    if (commit_go) begin
      alloc.route <= route_q;
      alloc.voice <= VOICE_W'(tgt_q);
    end
  end

  // voice note table and note map
  always_ff @(posedge clk) begin
    if (accept) begin
      vn_rd    <= vn_mem[next_voice];
      vn_vld_q <= vn_valid[next_voice];
      nm_rd    <= nm_mem[midi.note];
    end
    if (commit_go && kind_q == KIND_ON) begin
      vn_mem[tgt_q]  <= note_q;
      nm_mem[note_q] <= tgt_q;
    end
  end

  `VARA_ASSERT_NOW(a_ptr_range, 1'b1, int'(next_voice) < VOICES, "voice pointer out of range")
  `VARA_ASSERT_NEXT(a_accept_look, accept, state == LOOK, "accepted event did not advance")
  `VARA_ASSERT_NEXT(a_commit_out, commit_go, alloc_valid && state == IDLE,
                    "commit did not present a result")
  `VARA_ASSERT_NEXT(a_on_mapped, commit_go && kind_q == KIND_ON,
                    nm_valid[note_q] && alloc.route == ROUTE_ONE, "note-on left note unmapped")

endmodule

// ===== bench/voice_allocator_round_robin_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin voice allocator testbench
// Drives MIDI events through the allocator with random idling on both
// channels. A voice table and note map kept alongside the block predict the
// route and voice of every event, and each alloc transaction is checked
// against the oldest prediction. A directed opening covers drops, broadcast,
// note zero, retriggers and voice wrap. A random body of mostly well-formed
// note-on/note-off traffic follows, with one long receiver hold-off.
// ----------------------------------------------------------------------------
package voice_route_tb_pkg;

  import vara_pkg::*;

  class voice_route_tracker_t #(int VOICES = VOICES_DEF);
    int       next_voice;
    bit [6:0] voice_note [VOICES];
    bit       mapped [NOTES];
    int       map_voice [NOTES];
    alloc_t   routes [$];
    int       accepted;
    int       errors;

    function new();
      next_voice = VOICES - 1;
      foreach (voice_note[i]) voice_note[i] = '0;
      foreach (mapped[i]) begin
        mapped[i]    = 1'b0;
        map_voice[i] = 0;
      end
      accepted = 0;
      errors   = 0;
    endfunction

    function void note_event(midi_t m);
      alloc_t exp;
      int     v;
      exp       = '0;
      exp.route = ROUTE_ALL;
      if (m.kind == KIND_ON) begin
        v          = next_voice;
        next_voice = (v == 0) ? VOICES - 1 : v - 1;
        if (voice_note[v] != 0) mapped[voice_note[v]] = 1'b0;
        voice_note[v]     = m.note;
        mapped[m.note]    = 1'b1;
        map_voice[m.note] = v;
        exp.route         = ROUTE_ONE;
        exp.voice         = VOICE_W'(v);
      end else if (m.kind == KIND_OFF) begin
        if (mapped[m.note]) begin
          v              = map_voice[m.note];
          mapped[m.note] = 1'b0;
          voice_note[v]  = '0;
          exp.route      = ROUTE_ONE;
          exp.voice      = VOICE_W'(v);
        end else begin
          exp.route = ROUTE_DROP;
        end
      end
      routes.push_back(exp);
      accepted++;
    endfunction

    function void check_alloc(alloc_t got);
      alloc_t exp;
      if (routes.size() == 0) begin
        $display("%0t: unexpected transaction route %0d voice %0d", $time,
                 got.route, got.voice);
        errors++;
        return;
      end
      exp = routes.pop_front();
      if (got.route !== exp.route) begin
        $display("%0t: route expected %0d actual %0d", $time, exp.route, got.route);
        errors++;
      end
      if (got.voice !== exp.voice) begin
        $display("%0t: voice expected %0d actual %0d", $time, exp.voice, got.voice);
        errors++;
      end
    endfunction
  endclass

endpackage

module voice_allocator_round_robin_unit_tb;

  import vara_pkg::*;
  import voice_route_tb_pkg::*;

  localparam int                VOICES     = VOICES_DEF;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;
  localparam int                RANDOM_EVENTS = 830;
  localparam int                QUIET_EVENTS  = 100;
  localparam int                CYCLE_LIMIT   = 250000;

  logic   clk;
  logic   rst;
  midi_t  midi;
  logic   midi_valid;
  logic   midi_stall;
  alloc_t alloc;
  logic   alloc_valid;
  logic   alloc_stall;
  bit     quiet = 1'b0;
  int     cycles = 0;

  voice_route_tracker_t tracker = new();

  voice_allocator_round_robin_unit #(.VOICES(VOICES)) dut (
    .clk         (clk),
    .rst         (rst),
    .midi        (midi),
    .midi_valid  (midi_valid),
    .midi_stall  (midi_stall),
    .alloc       (alloc),
    .alloc_valid (alloc_valid),
    .alloc_stall (alloc_stall)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_event(input logic [KIND_W-1:0] kind, input int note);
    midi_t m;
    m.kind = kind;
    m.note = NOTE_W'(note);
    midi       <= m;
    midi_valid <= 1'b1;
    do @(posedge clk); while (midi_stall);
    tracker.note_event(m);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      midi_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // receiver: check transactions, stall in bursts, hold off once for long
  initial begin
    int stall_left;
    bit held_long;
    stall_left = 0;
    held_long  = 1'b0;
    alloc_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && alloc_valid && !alloc_stall) tracker.check_alloc(alloc);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held_long && tracker.accepted >= 40) begin
        held_long  = 1'b1;
        stall_left = 90;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      alloc_stall <= (stall_left > 0);
    end
  end

  initial begin
    int sounding [$];
    int pick;
    int sel;
    int note;
    rst        <= 1'b1;
    midi_valid <= 1'b0;
    midi       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(KIND_OFF, 5);
    send_event(KIND_OTHER, 127);
    send_event(KIND_RSVD, 0);
    send_event(KIND_ON, 0);
    send_event(KIND_ON, 127);
    send_event(KIND_ON, 60);
    send_event(KIND_ON, 60);
    send_event(KIND_OFF, 60);
    for (int i = 1; i <= 4; i++) send_event(KIND_ON, i);
    send_event(KIND_ON, 60);
    send_event(KIND_OFF, 0);
    send_event(KIND_ON, 85);
    send_event(KIND_OFF, 127);
    send_event(KIND_ON, 42);
    send_event(KIND_OFF, 60);
    send_event(KIND_ON, 0);
    send_event(KIND_ON, 127);
    send_event(KIND_OFF, 127);
    send_event(KIND_RSVD, 127);
    send_event(KIND_OFF, 0);
    send_event(KIND_OFF, 42);

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i == RANDOM_EVENTS - QUIET_EVENTS) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        note = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 23);
        sounding.push_back(note);
        if (sounding.size() > 16) sounding.delete(0);
        send_event(KIND_ON, note);
      end else if (sel < 85) begin
        if (sounding.size() > 0 && $urandom_range(0, 7) != 0) begin
          pick = $urandom_range(0, sounding.size() - 1);
          note = sounding[pick];
          sounding.delete(pick);
        end else begin
          note = $urandom_range(0, 127);
        end
        send_event(KIND_OFF, note);
      end else if (sel < 95) begin
        send_event(KIND_OTHER, $urandom_range(0, 127));
      end else begin
        send_event(KIND_RSVD, $urandom_range(0, 127));
      end
    end
    midi_valid <= 1'b0;

    while (tracker.routes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (tracker.errors == 0 && tracker.routes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
